// ----- rtl/alil_pkg.sv -----
// ----------------------------------------------------------------------------
// Angle linear interpolator package
// Control flags that travel down the pipeline beside each word.
// ----------------------------------------------------------------------------
package alil_pkg;

	// Per-word control flags carried from stage to stage.
	typedef struct packed {
		logic valid;   // a word occupies this stage
		logic bypass;  // result is the carried angle as it stands
		logic neg;     // the offset is subtracted with floor rounding
	} alil_ctl_t;

endpackage

// ----- rtl/angle_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// Angle linear interpolator
// Interpolates inclination or azimuth between two stations along the
// shorter arc and wraps the result into one turn.
// ----------------------------------------------------------------------------
// Start and done are separated by the front-end stages, the row of one-bit
// restoring divider cells (one per dividend bit) and the output register.
// Throughput: one word per cycle; busy is always low.
// Reset clears every stage valid flag, so no done pulse follows a reset
// until a new word is started. The receiver cannot stall the output.
module angle_linear_interpolator import alil_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cmd,
	input  logic [POSITION_BITS-1:0] query_position,
	input  logic [POSITION_BITS-1:0] first_position,
	input  logic [ANGLE_BITS-1:0]    first_inclination,
	input  logic [ANGLE_BITS-1:0]    first_azimuth,
	input  logic [POSITION_BITS-1:0] second_position,
	input  logic [ANGLE_BITS-1:0]    second_inclination,
	input  logic [ANGLE_BITS-1:0]    second_azimuth,
	output logic                     done,
	output logic [ANGLE_BITS-1:0]    angle_out
);

	localparam int A = ANGLE_BITS;
	localparam int P = POSITION_BITS;
	localparam int N = A + P;

	alil_ctl_t    ctl_c  [0:N];
	logic [A-1:0] base_c [0:N];
	logic [P-1:0] dp_c   [0:N];
	logic [P-1:0] rem_c  [0:N];
	logic [N-1:0] dvd_c  [0:N];
	logic [A-1:0] quo_c  [0:N];

	logic [A-1:0] off;
	logic         rem_nz;
	logic         done_q;
	logic [A-1:0] angle_q;

	// The pipeline never holds off a new word.
	assign busy = 1'b0;

	// Operand preparation and product.
	alil_front #(
		.ANGLE_BITS    (A),
		.POSITION_BITS (P)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.take               (start && !busy),
		.cmd                (cmd),
		.query_position     (query_position),
		.first_position     (first_position),
		.first_inclination  (first_inclination),
		.first_azimuth      (first_azimuth),
		.second_position    (second_position),
		.second_inclination (second_inclination),
		.second_azimuth     (second_azimuth),
		.ctl                (ctl_c[0]),
		.base               (base_c[0]),
		.span               (dp_c[0]),
		.product            (dvd_c[0])
	);

	assign rem_c[0] = '0;
	assign quo_c[0] = '0;

	// Row of divider cells, one dividend bit per cell.
	for (genvar i = 0; i < N; i++) begin : g_cell
		alil_div_cell #(
			.ANGLE_BITS    (A),
			.POSITION_BITS (P)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[i]),
			.base_in  (base_c[i]),
			.dp_in    (dp_c[i]),
			.rem_in   (rem_c[i]),
			.dvd_in   (dvd_c[i]),
			.quo_in   (quo_c[i]),
			.ctl_out  (ctl_c[i+1]),
			.base_out (base_c[i+1]),
			.dp_out   (dp_c[i+1]),
			.rem_out  (rem_c[i+1]),
			.dvd_out  (dvd_c[i+1]),
			.quo_out  (quo_c[i+1])
		);
	end

	// Signed offset: a negative quotient is floored, so a remainder adds one.
	always_comb begin
		rem_nz = (rem_c[N] != '0);
		if (ctl_c[N].neg) begin
			off = '0 - (quo_c[N] + A'(rem_nz));
		end else begin
			off = quo_c[N];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= ctl_c[N].bypass ? base_c[N] : (base_c[N] + off);
	end

	assign done      = done_q;
	assign angle_out = angle_q;

endmodule

// ----- rtl/alil_front.sv -----
// ----------------------------------------------------------------------------
// Angle linear interpolator front end
// Selects the angles, resolves special cases and the shorter arc, and forms
// the product of angle span and position offset over three stages.
// ----------------------------------------------------------------------------
module alil_front import alil_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic                                  cmd,
	input  logic [POSITION_BITS-1:0]              query_position,
	input  logic [POSITION_BITS-1:0]              first_position,
	input  logic [ANGLE_BITS-1:0]                 first_inclination,
	input  logic [ANGLE_BITS-1:0]                 first_azimuth,
	input  logic [POSITION_BITS-1:0]              second_position,
	input  logic [ANGLE_BITS-1:0]                 second_inclination,
	input  logic [ANGLE_BITS-1:0]                 second_azimuth,
	output alil_ctl_t                             ctl,
	output logic [ANGLE_BITS-1:0]                 base,
	output logic [POSITION_BITS-1:0]              span,
	output logic [ANGLE_BITS+POSITION_BITS-1:0]   product
);

	localparam int A  = ANGLE_BITS;
	localparam int P  = POSITION_BITS;
	localparam int N  = A + P;
	localparam int PL = (P + 1) / 2;
	localparam int PH = P - PL;
	localparam logic [A-1:0] HALF = {1'b1, {(A-1){1'b0}}};

	logic [A-1:0] a1, a2, d_up, d_dn, dmag, bypass_val;
	logic         az_special, empty, dneg, tneg;
	logic [P-1:0] tmag;
	alil_ctl_t    ctl_d;

	alil_ctl_t    ctl_s1, ctl_s2, ctl_s3;
	logic [A-1:0] base_s1, base_s2, base_s3;
	logic [A-1:0] dmag_s1;
	logic [P-1:0] tmag_s1;
	logic [P-1:0] dp_s1, dp_s2, dp_s3;
	logic [A+PL-1:0] pp_lo_s2;
	logic [A+PH-1:0] pp_hi_s2;
	logic [N-1:0] prod_s3;

	// Angle selection, special cases and shorter-arc span.
	always_comb begin
		a1         = cmd ? first_azimuth : first_inclination;
		a2         = cmd ? second_azimuth : second_inclination;
		az_special = cmd && (first_inclination == '0);
		empty      = (second_position <= first_position);
		if (az_special) begin
			bypass_val = (second_inclination != '0) ? second_azimuth : '0;
		end else begin
			bypass_val = a2;
		end
		d_up = a2 - a1;
		d_dn = a1 - a2;
		if (a2 > a1) begin
			// Going up by more than half a turn means going down the other way.
			dneg = (d_up > HALF);
			dmag = (d_up > HALF) ? d_dn : d_up;
		end else begin
			dneg = (d_dn <= HALF) && (d_dn != '0);
			dmag = (d_dn > HALF) ? d_up : d_dn;
		end
		tneg = (first_position > query_position);
		tmag = tneg ? (first_position - query_position)
		            : (query_position - first_position);
		ctl_d.valid  = take;
		ctl_d.bypass = az_special || empty;
		ctl_d.neg    = dneg ^ tneg;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Payload: operands, two partial products, then their sum.
	always_ff @(posedge clk) begin
		base_s1  <= (az_special || empty) ? bypass_val : a1;
		dmag_s1  <= dmag;
		tmag_s1  <= tmag;
		dp_s1    <= second_position - first_position;

		base_s2  <= base_s1;
		dp_s2    <= dp_s1;
		pp_lo_s2 <= (A+PL)'(dmag_s1) * (A+PL)'(tmag_s1[PL-1:0]);
		pp_hi_s2 <= (A+PH)'(dmag_s1) * (A+PH)'(tmag_s1[P-1:PL]);

		base_s3  <= base_s2;
		dp_s3    <= dp_s2;
		prod_s3  <= {pp_hi_s2, {PL{1'b0}}} + {{PH{1'b0}}, pp_lo_s2};
	end

	assign ctl     = ctl_s3;
	assign base    = base_s3;
	assign span    = dp_s3;
	assign product = prod_s3;

endmodule

// ----- rtl/alil_div_cell.sv -----
// ----------------------------------------------------------------------------
// Angle linear interpolator divider cell
// One restoring division step: brings in one dividend bit, subtracts the
// divisor when it fits, and hands everything to the next cell.
// ----------------------------------------------------------------------------
module alil_div_cell import alil_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  alil_ctl_t                             ctl_in,
	input  logic [ANGLE_BITS-1:0]                 base_in,
	input  logic [POSITION_BITS-1:0]              dp_in,
	input  logic [POSITION_BITS-1:0]              rem_in,
	input  logic [ANGLE_BITS+POSITION_BITS-1:0]   dvd_in,
	input  logic [ANGLE_BITS-1:0]                 quo_in,
	output alil_ctl_t                             ctl_out,
	output logic [ANGLE_BITS-1:0]                 base_out,
	output logic [POSITION_BITS-1:0]              dp_out,
	output logic [POSITION_BITS-1:0]              rem_out,
	output logic [ANGLE_BITS+POSITION_BITS-1:0]   dvd_out,
	output logic [ANGLE_BITS-1:0]                 quo_out
);

	localparam int A = ANGLE_BITS;
	localparam int P = POSITION_BITS;
	localparam int N = A + P;

	logic [P:0]   trial, diff;
	logic         fits;
	alil_ctl_t    ctl_q;
	logic [A-1:0] base_q, quo_q;
	logic [P-1:0] dp_q, rem_q;
	logic [N-1:0] dvd_q;

	// Trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial = {rem_in, dvd_in[N-1]};
		diff  = trial - {1'b0, dp_in};
		fits  = (trial >= {1'b0, dp_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	// Only the low quotient bits are kept; the result wraps to one turn.
	always_ff @(posedge clk) begin
		base_q <= base_in;
		dp_q   <= dp_in;
		rem_q  <= fits ? diff[P-1:0] : trial[P-1:0];
		dvd_q  <= {dvd_in[N-2:0], 1'b0};
		quo_q  <= {quo_in[A-2:0], fits};
	end

	assign ctl_out  = ctl_q;
	assign base_out = base_q;
	assign dp_out   = dp_q;
	assign rem_out  = rem_q;
	assign dvd_out  = dvd_q;
	assign quo_out  = quo_q;

endmodule

// ----- rtl/alil_checker.sv -----
// ----------------------------------------------------------------------------
// Angle linear interpolator checker
// Watches the top-level ports for timing of done and for special cases.
// ----------------------------------------------------------------------------
module alil_checker #(
	parameter int ANGLE_BITS    = 16,
	parameter int POSITION_BITS = 32
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     cmd,
	input logic [POSITION_BITS-1:0] first_position,
	input logic [ANGLE_BITS-1:0]    first_inclination,
	input logic [POSITION_BITS-1:0] second_position,
	input logic [ANGLE_BITS-1:0]    second_inclination,
	input logic                     done,
	input logic [ANGLE_BITS-1:0]    angle_out
);

	localparam int LAT = ANGLE_BITS + POSITION_BITS + 4;
	localparam int CW  = $clog2(LAT + 1);

	logic [CW-1:0] warm_q;
	logic          warm;

	// Counts cycles since reset so that old history is not trusted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CW'(LAT)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign warm = (warm_q == CW'(LAT));

	// The pipeline always takes a new word.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");

	// Done is high only for an accepted word, and every accepted word produces done.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("done does not match accepted word");

	// Azimuth with both stations vertical gives zero.
	a_vertical_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && cmd && (first_inclination == '0)
			&& (second_inclination == '0), LAT)) |-> (angle_out == '0))
		else $error("vertical azimuth not zero");

	// Inclination over an empty interval returns the second inclination.
	a_empty_incl: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && !cmd
			&& (second_position <= first_position), LAT))
		|-> (angle_out == $past(second_inclination, LAT)))
		else $error("empty interval inclination mismatch");

endmodule

bind angle_linear_interpolator alil_checker #(
	.ANGLE_BITS    (ANGLE_BITS),
	.POSITION_BITS (POSITION_BITS)
) u_alil_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.cmd                (cmd),
	.first_position     (first_position),
	.first_inclination  (first_inclination),
	.second_position    (second_position),
	.second_inclination (second_inclination),
	.done               (done),
	.angle_out          (angle_out)
);
